/* rtl/core/double_ended_queue_core_defines.svh */
// Assertion macros for the deque core.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define DEQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define DEQ_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define DEQ_ASSERT(label, clk, rst_n, prop, msg)

`define DEQ_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

/* rtl/core/deq_pkg.sv */
package deq_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W   = 11;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_RIGHT = 2'd0,
        KIND_POP_LEFT   = 2'd1,
        KIND_POP_RIGHT  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_POP_EMPTY  = 2'd1,
        STATUS_PUSH_FULL  = 2'd2
    } status_t;

endpackage

/* rtl/core/deq_if.sv */
interface deq_req_if;
    logic                           valid;
    logic                           ready;
    logic [deq_pkg::KIND_W-1:0]     kind;
    logic [deq_pkg::VALUE_W-1:0]    push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [deq_pkg::VALUE_W-1:0]    popped_value;
    logic [deq_pkg::STATUS_W-1:0]   status;
    logic [deq_pkg::OCC_W-1:0]      occupancy;
    logic                           is_empty;
    logic [deq_pkg::VALUE_W-1:0]    left_peek;
    logic [deq_pkg::VALUE_W-1:0]    right_peek;

    modport source (output valid, output popped_value, output status, output occupancy,
                    output is_empty, output left_peek, output right_peek, input ready);
    modport sink   (input valid, input popped_value, input status, input occupancy,
                    input is_empty, input left_peek, input right_peek, output ready);
endinterface

/* rtl/core/double_ended_queue_core.sv */
// channel  role    payload
// req      sink    kind, push_value
// rsp      source  popped_value, status, occupancy, is_empty, left_peek, right_peek
//
// A push, a refused request or a no-op loads the result register directly; a pop
// that leaves entries waits in a read state for the new end entry from the store.
// Both end entries are held in registers, so each request needs at most one read.
// Reset clears count, cached ends, left pointer (right to DEPTH-1), not the store.
// A result not yet taken holds off every new request; a pop that reads also
// holds off requests in the cycle after it is accepted.
module double_ended_queue_core #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req,
    deq_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = (VALUE_WIDTH < deq_pkg::VALUE_W) ? VALUE_WIDTH : deq_pkg::VALUE_W;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [SW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [SW-1:0] rd_data;

    deq_ctrl #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* rtl/core/deq_mem.sv */
module deq_mem #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF,
    parameter int WIDTH = deq_pkg::VALUE_W
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/deq_ctrl.sv */
`include "double_ended_queue_core_defines.svh"

module deq_ctrl #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    deq_req_if.sink                  req,
    deq_rsp_if.source                rsp,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [(VALUE_WIDTH < deq_pkg::VALUE_W ? VALUE_WIDTH : deq_pkg::VALUE_W)-1:0] wr_data,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [(VALUE_WIDTH < deq_pkg::VALUE_W ? VALUE_WIDTH : deq_pkg::VALUE_W)-1:0] rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (VALUE_WIDTH < deq_pkg::VALUE_W) ? VALUE_WIDTH : deq_pkg::VALUE_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_LEFT,
        ST_READ_RIGHT
    } state_t;

    state_t                 state_reg, state_next;
    logic [AW-1:0]          left_reg, left_next;
    logic [AW-1:0]          right_reg, right_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [SW-1:0]          lpeek_reg, lpeek_next;
    logic [SW-1:0]          rpeek_reg, rpeek_next;
    logic [SW-1:0]          pend_popped_reg, pend_popped_next;

    logic                   out_valid_reg;
    logic [SW-1:0]          out_popped_reg, out_popped_next;
    deq_pkg::status_t       out_status_reg, out_status_next;
    logic [CW-1:0]          out_count_reg;
    logic [SW-1:0]          out_lpeek_reg;
    logic [SW-1:0]          out_rpeek_reg;

    logic                   load_out;
    logic                   accept;
    logic                   is_full;
    logic                   is_empty_now;
    logic [AW-1:0]          left_inc;
    logic [AW-1:0]          right_inc;
    logic [AW-1:0]          right_dec;
    logic [SW-1:0]          value_in;
    deq_pkg::kind_t         kind_in;

    assign req.ready    = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept       = req.valid && req.ready;
    assign is_full      = (count_reg == CW'(DEPTH));
    assign is_empty_now = (count_reg == '0);
    assign left_inc     = (left_reg == AW'(DEPTH - 1)) ? '0 : left_reg + AW'(1);
    assign right_inc    = (right_reg == AW'(DEPTH - 1)) ? '0 : right_reg + AW'(1);
    assign right_dec    = (right_reg == '0) ? AW'(DEPTH - 1) : right_reg - AW'(1);
    assign value_in     = req.push_value[SW-1:0];
    assign kind_in      = deq_pkg::kind_t'(req.kind);

    always_comb
    begin
        state_next       = state_reg;
        left_next        = left_reg;
        right_next       = right_reg;
        count_next       = count_reg;
        lpeek_next       = lpeek_reg;
        rpeek_next       = rpeek_reg;
        pend_popped_next = pend_popped_reg;
        out_popped_next  = '0;
        out_status_next  = deq_pkg::STATUS_OK;
        load_out         = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = right_inc;
        wr_data          = value_in;
        rd_en            = 1'b0;
        rd_addr          = left_inc;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (kind_in)
                        deq_pkg::KIND_PUSH_RIGHT:
                        begin
                            load_out = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = deq_pkg::STATUS_PUSH_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                right_next = right_inc;
                                count_next = count_reg + CW'(1);
                                rpeek_next = value_in;
                                if (is_empty_now)
                                begin
                                    lpeek_next = value_in;
                                end
                            end
                        end
                        deq_pkg::KIND_POP_LEFT:
                        begin
                            if (is_empty_now)
                            begin
                                load_out        = 1'b1;
                                out_status_next = deq_pkg::STATUS_POP_EMPTY;
                            end
                            else
                            begin
                                left_next  = left_inc;
                                count_next = count_reg - CW'(1);
                                if (count_reg == CW'(1))
                                begin
                                    load_out        = 1'b1;
                                    out_popped_next = lpeek_reg;
                                    lpeek_next      = '0;
                                    rpeek_next      = '0;
                                end
                                else
                                begin
                                    pend_popped_next = lpeek_reg;
                                    rd_en            = 1'b1;
                                    rd_addr          = left_inc;
                                    state_next       = ST_READ_LEFT;
                                end
                            end
                        end
                        deq_pkg::KIND_POP_RIGHT:
                        begin
                            if (is_empty_now)
                            begin
                                load_out        = 1'b1;
                                out_status_next = deq_pkg::STATUS_POP_EMPTY;
                            end
                            else
                            begin
                                right_next = right_dec;
                                count_next = count_reg - CW'(1);
                                if (count_reg == CW'(1))
                                begin
                                    load_out        = 1'b1;
                                    out_popped_next = rpeek_reg;
                                    lpeek_next      = '0;
                                    rpeek_next      = '0;
                                end
                                else
                                begin
                                    pend_popped_next = rpeek_reg;
                                    rd_en            = 1'b1;
                                    rd_addr          = right_dec;
                                    state_next       = ST_READ_RIGHT;
                                end
                            end
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_LEFT:
            begin
                lpeek_next      = rd_data;
                out_popped_next = pend_popped_reg;
                load_out        = 1'b1;
                state_next      = ST_IDLE;
            end
            ST_READ_RIGHT:
            begin
                rpeek_next      = rd_data;
                out_popped_next = pend_popped_reg;
                load_out        = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            left_reg      <= '0;
            right_reg     <= AW'(DEPTH - 1);
            count_reg     <= '0;
            lpeek_reg     <= '0;
            rpeek_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            right_reg <= right_next;
            count_reg <= count_next;
            lpeek_reg <= lpeek_next;
            rpeek_reg <= rpeek_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_popped_reg <= pend_popped_next;
        if (load_out)
        begin
            out_popped_reg <= out_popped_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= count_next;
            out_lpeek_reg  <= lpeek_next;
            out_rpeek_reg  <= rpeek_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = deq_pkg::VALUE_W'(out_popped_reg);
    assign rsp.status       = out_status_reg;
    assign rsp.occupancy    = deq_pkg::OCC_W'(out_count_reg);
    assign rsp.is_empty     = (out_count_reg == '0);
    assign rsp.left_peek    = deq_pkg::VALUE_W'(out_lpeek_reg);
    assign rsp.right_peek   = deq_pkg::VALUE_W'(out_rpeek_reg);

    `DEQ_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > CW'(DEPTH), "count beyond depth")
    `DEQ_ASSERT(a_empty_peeks, clk, rst_n, (count_reg == '0) |-> (lpeek_reg == '0 && rpeek_reg == '0), "peeks not cleared when empty")
    `DEQ_ASSERT(a_read_one_cycle, clk, rst_n, (state_reg != ST_IDLE) |=> (state_reg == ST_IDLE), "read state held too long")
    `DEQ_ASSERT_NEVER(a_read_out_busy, clk, rst_n, (state_reg != ST_IDLE) && out_valid_reg, "result register busy during read")
    `DEQ_ASSERT_NEVER(a_rw_overlap, clk, rst_n, wr_en && rd_en, "write and read in one cycle")

endmodule
